FILE: rtl/core/ofr_pkg.sv
// shared types and constants for the orifice flow rate pipeline
`timescale 1ns / 1ps

package ofr_pkg;

    // fraction bits of the root, in sqrt(Pa)
    localparam int ROOT_FRAC_BITS = 8;

    // port widths
    localparam int PRES_W     = 28;
    localparam int OPEN_W     = 18;
    localparam int X_W        = OPEN_W - 1;
    localparam int D_W        = 17;
    localparam int FC_W       = 24;
    localparam int T_W        = 20;
    localparam int FLOW_W     = 41;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    // root datapath
    localparam int DP_W       = PRES_W;
    localparam int SQ_IN_W    = DP_W + 2 * ROOT_FRAC_BITS;
    localparam int SQ_OUT_W   = (SQ_IN_W + 1) / 2;
    localparam int SQ_PAD_W   = 2 * SQ_OUT_W;
    localparam int SQ_REM_W   = SQ_OUT_W + 2;
    localparam int SQ_STAGES  = SQ_OUT_W;

    // quadratic coefficient divider
    localparam int NUM_W      = 2 * T_W + 2;
    localparam int DEN_W      = 2 * T_W + 1;
    localparam int DIV_FRAC   = 20;
    localparam int DIV_Q_W    = DIV_FRAC + 1;
    localparam int DIV_STAGES = DIV_Q_W;

    // area and product datapath
    localparam int PA_W       = D_W + X_W;
    localparam int SQRT2_W    = 25;
    localparam int XS_W       = X_W + SQRT2_W;
    localparam int SEAT_W     = XS_W + 1;
    localparam int G_W        = SEAT_W - 16;
    localparam int BASE_W     = X_W + G_W;
    localparam int BASE_LO_W  = BASE_W / 2;
    localparam int PI_W       = 18;
    localparam int BPI_W      = BASE_LO_W + PI_W;
    localparam int BPI_FULL_W = BASE_W + PI_W;
    localparam int AREA_W     = BPI_FULL_W - 24;
    localparam int AREA_LO_W  = AREA_W / 2;
    localparam int AFC_W      = AREA_LO_W + FC_W;
    localparam int AP_W       = AREA_W + FC_W;
    localparam int AP_LO_W    = AP_W / 2;
    localparam int RT_W       = SQ_OUT_W;
    localparam int PP_W       = AP_LO_W + RT_W;
    localparam int PROD_W     = AP_W + RT_W;
    localparam int MAG_SH     = 24 + ROOT_FRAC_BITS;
    localparam int MAG_W      = PROD_W - MAG_SH;
    localparam int SR_W       = SQ_OUT_W + DIV_Q_W;

    // pipeline alignment
    localparam int AREA_STAGES = 6;
    localparam int ALIGN       = (SQ_STAGES > DIV_STAGES) ? SQ_STAGES : DIV_STAGES;
    localparam int SQ_DLY      = ALIGN - SQ_STAGES;
    localparam int DIV_DLY     = ALIGN - DIV_STAGES;
    localparam int AREA_DLY    = ALIGN - AREA_STAGES;

    // fixed-point constants
    localparam logic [PI_W-1:0]    PI_Q16     = 18'd205887;
    localparam logic [SQRT2_W-1:0] SQRT2_Q24  = 25'd23726566;
    localparam logic [FLOW_W-1:0]  FLOW_LIMIT = 41'd1000000000000;

    localparam logic AREA_SEAT   = 1'b0;
    localparam logic AREA_PISTON = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AREA_MODE     = 2'd0,
        CFG_BORE_DIAMETER = 2'd1,
        CFG_FLOW_COEFF    = 2'd2,
        CFG_REG_THRESHOLD = 2'd3
    } cfg_index_t;

    typedef logic [DP_W-1:0]     dp_t;
    typedef logic [SQ_PAD_W-1:0] sq_pad_t;
    typedef logic [SQ_REM_W-1:0] sq_rem_t;
    typedef logic [SQ_OUT_W-1:0] sq_root_t;
    typedef logic [NUM_W-1:0]    num_t;
    typedef logic [DEN_W-1:0]    den_t;
    typedef logic [DIV_Q_W-1:0]  quot_t;
    typedef logic [PROD_W-1:0]   prod_t;
    typedef logic [MAG_W-1:0]    mag_t;
    typedef logic [FLOW_W-1:0]   flow_t;
    typedef logic [RT_W-1:0]     rt_t;

endpackage

FILE: rtl/core/ofr_isqrt.sv
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps

module ofr_isqrt
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  ofr_pkg::dp_t     op,
    output logic             out_valid,
    output ofr_pkg::sq_root_t root
);

    typedef struct packed {
        ofr_pkg::sq_rem_t  rem;
        ofr_pkg::sq_root_t root;
        ofr_pkg::sq_pad_t  op;
    } sq_step_t;

    logic     vld_reg  [ofr_pkg::SQ_STAGES];
    sq_step_t step_reg [ofr_pkg::SQ_STAGES];

    for (genvar i = 0; i < ofr_pkg::SQ_STAGES; i++) begin : g_step
        sq_step_t         prev;
        sq_step_t         step_next;
        logic             vld_prev;
        ofr_pkg::sq_rem_t rem_sh;
        ofr_pkg::sq_rem_t trial;
        logic             fits;

        if (i == 0) begin : g_first
            // operand scaled by 2^(2*frac) so the root carries frac bits
            assign prev = '{rem: '0, root: '0,
                            op: ofr_pkg::sq_pad_t'(op) << (2 * ofr_pkg::ROOT_FRAC_BITS)};
            assign vld_prev = in_valid;
        end
        else begin : g_rest
            assign prev     = step_reg[i-1];
            assign vld_prev = vld_reg[i-1];
        end

        always_comb
        begin
            rem_sh = {prev.rem[ofr_pkg::SQ_REM_W-3:0], prev.op[ofr_pkg::SQ_PAD_W-1 -: 2]};
            trial  = {prev.root, 2'b01};
            fits   = (rem_sh >= trial);
            step_next.rem  = fits ? (rem_sh - trial) : rem_sh;
            step_next.root = {prev.root[ofr_pkg::SQ_OUT_W-2:0], fits};
            step_next.op   = prev.op << 2;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else
            begin
                vld_reg[i] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            step_reg[i] <= step_next;
        end
    end

    assign out_valid = vld_reg[ofr_pkg::SQ_STAGES-1];
    assign root      = step_reg[ofr_pkg::SQ_STAGES-1].root;

endmodule

FILE: rtl/core/ofr_div.sv
// pipelined restoring divider for the quadratic coefficient, one quotient bit per stage
`timescale 1ns / 1ps

module ofr_div
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  ofr_pkg::num_t num,
    input  ofr_pkg::den_t den,
    output logic          out_valid,
    output ofr_pkg::quot_t quot
);

    typedef struct packed {
        ofr_pkg::den_t  rem;
        ofr_pkg::quot_t q;
    } div_step_t;

    logic      vld_reg  [ofr_pkg::DIV_STAGES];
    div_step_t step_reg [ofr_pkg::DIV_STAGES];

    for (genvar i = 0; i < ofr_pkg::DIV_STAGES; i++) begin : g_step
        ofr_pkg::num_t  cand;
        ofr_pkg::quot_t q_prev;
        logic           vld_prev;
        logic           fits;
        div_step_t      step_next;

        if (i == 0) begin : g_first
            // integer bit first: quotient stays below two
            assign cand     = num;
            assign q_prev   = '0;
            assign vld_prev = in_valid;
        end
        else begin : g_rest
            assign cand     = {step_reg[i-1].rem, 1'b0};
            assign q_prev   = step_reg[i-1].q;
            assign vld_prev = vld_reg[i-1];
        end

        always_comb
        begin
            fits = (cand >= {1'b0, den});
            step_next.rem = ofr_pkg::den_t'(fits ? (cand - {1'b0, den}) : cand);
            step_next.q   = {q_prev[ofr_pkg::DIV_Q_W-2:0], fits};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else
            begin
                vld_reg[i] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            step_reg[i] <= step_next;
        end
    end

    assign out_valid = vld_reg[ofr_pkg::DIV_STAGES-1];
    assign quot      = step_reg[ofr_pkg::DIV_STAGES-1].q;

endmodule

FILE: rtl/core/orifice_flow_rate.sv
// orifice flow rate top level: signed volume flow from two pressures and an opening
`timescale 1ns / 1ps

// A fully pipelined unit: a word is taken on every cycle that start is high (busy stays
// low), and its result appears on flow_mm3_s / saturated with done high for one cycle.
// The square root pipeline (one root bit per stage, 22 stages) sets the depth of the unit;
// it runs alongside the quadratic coefficient divider and the area multipliers; the setup
// stages feed it, and two multiply stages, the root select, one add stage and the output
// register follow it.
// Results are never held back, so the receiver must take done whenever it is asserted.
// Configuration registers are read live by the pipeline:
// write them only while no word is in flight. The flow is sign * coeff * area * root(|dp|)
// above the threshold (a matched quadratic at or below it), saturated to +/-1e12 mm^3/s.

module orifice_flow_rate
(
    input  logic                                clk,
    input  logic                                rst_n,

    // command side
    input  logic                                start,
    output logic                                busy,
    input  logic signed [ofr_pkg::PRES_W-1:0]   pressure_in_pa,
    input  logic signed [ofr_pkg::PRES_W-1:0]   pressure_out_pa,
    input  logic signed [ofr_pkg::OPEN_W-1:0]   opening_um,

    // result side
    output logic                                done,
    output logic signed [ofr_pkg::FLOW_W-1:0]   flow_mm3_s,
    output logic                                saturated,

    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [ofr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ofr_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // sideband that travels with each word through the area path
    typedef struct packed {
        logic vld;
        logic neg;   // flow direction is reversed
        logic sel;   // dp above threshold: plain root
        logic zero;  // equal pressures
    } side_t;

    typedef struct packed {
        side_t                     side;
        logic [ofr_pkg::AP_W-1:0]  p;
    } area_out_t;

    // configuration registers
    logic                         area_mode_reg;
    logic [ofr_pkg::D_W-1:0]      bore_diameter_um_reg;
    logic [ofr_pkg::FC_W-1:0]     flow_coeff_reg;
    logic [ofr_pkg::T_W-1:0]      reg_threshold_pa_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_mode_reg        <= ofr_pkg::AREA_PISTON;
            bore_diameter_um_reg <= 17'd10000;
            flow_coeff_reg       <= 24'd570;
            reg_threshold_pa_reg <= 20'd10000;
        end
        else if (cfg_wr_en)
        begin
            unique case (ofr_pkg::cfg_index_t'(cfg_index))
                ofr_pkg::CFG_AREA_MODE:     area_mode_reg        <= cfg_data[0];
                ofr_pkg::CFG_BORE_DIAMETER: bore_diameter_um_reg <= cfg_data[ofr_pkg::D_W-1:0];
                ofr_pkg::CFG_FLOW_COEFF:    flow_coeff_reg       <= cfg_data[ofr_pkg::FC_W-1:0];
                ofr_pkg::CFG_REG_THRESHOLD: reg_threshold_pa_reg <= cfg_data[ofr_pkg::T_W-1:0];
            endcase
        end
    end

    // every cycle is open for a new word
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // stage 1: pressure difference, magnitude and clamped opening
    // ------------------------------------------------------------------
    logic signed [ofr_pkg::PRES_W:0] diff;
    logic                            s1_vld_reg;
    logic                            s1_neg_reg;
    ofr_pkg::dp_t                    s1_dp_reg;
    logic [ofr_pkg::X_W-1:0]         s1_x_reg;

    assign diff = (ofr_pkg::PRES_W + 1)'(pressure_in_pa) - (ofr_pkg::PRES_W + 1)'(pressure_out_pa);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_neg_reg <= diff[ofr_pkg::PRES_W];
        // magnitude always fits the pressure width
        s1_dp_reg  <= diff[ofr_pkg::PRES_W] ? ofr_pkg::dp_t'(-diff) : ofr_pkg::dp_t'(diff);
        // negative opening counts as closed
        s1_x_reg   <= opening_um[ofr_pkg::OPEN_W-1] ? '0 : opening_um[ofr_pkg::X_W-1:0];
    end

    // ------------------------------------------------------------------
    // stage 2: branch select, quadratic numerator, first area products
    // ------------------------------------------------------------------
    logic [ofr_pkg::T_W+1:0]    three_t;
    logic [ofr_pkg::T_W+1:0]    three_t_minus;
    logic                       s2_vld_reg;
    logic                       s2_neg_reg;
    logic                       s2_sel_reg;
    logic                       s2_zero_reg;
    ofr_pkg::dp_t               s2_sqop_reg;
    ofr_pkg::num_t              s2_num_reg;
    logic [ofr_pkg::PA_W-1:0]   s2_pa_reg;
    logic [ofr_pkg::XS_W-1:0]   s2_xs_reg;
    logic [ofr_pkg::X_W-1:0]    s2_x_reg;
    ofr_pkg::den_t              den_reg;
    logic                       above_t;

    assign above_t       = (s1_dp_reg > ofr_pkg::dp_t'(reg_threshold_pa_reg));
    assign three_t       = {2'b00, reg_threshold_pa_reg} + {1'b0, reg_threshold_pa_reg, 1'b0};
    // only meaningful when dp is at or below the threshold
    assign three_t_minus = three_t - {2'b00, s1_dp_reg[ofr_pkg::T_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_neg_reg  <= s1_neg_reg;
        s2_sel_reg  <= above_t;
        s2_zero_reg <= (s1_dp_reg == '0);
        // the root unit serves both branches: sqrt(dp) or sqrt(T)
        s2_sqop_reg <= above_t ? s1_dp_reg : ofr_pkg::dp_t'(reg_threshold_pa_reg);
        s2_num_reg  <= s1_dp_reg[ofr_pkg::T_W-1:0] * three_t_minus;
        s2_pa_reg   <= bore_diameter_um_reg * s1_x_reg;
        s2_xs_reg   <= s1_x_reg * ofr_pkg::SQRT2_Q24;
        s2_x_reg    <= s1_x_reg;
        // 2*T*T; it stays steady only if the threshold is not written while words are in flight
        den_reg     <= (ofr_pkg::den_t'(reg_threshold_pa_reg)
                        * ofr_pkg::den_t'(reg_threshold_pa_reg)) << 1;
    end

    // ------------------------------------------------------------------
    // root and coefficient units
    // ------------------------------------------------------------------
    logic              sq_vld;
    ofr_pkg::sq_root_t sq_root;
    logic              dv_vld;
    ofr_pkg::quot_t    dv_quot;

    ofr_isqrt u_isqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_vld_reg),
        .op        (s2_sqop_reg),
        .out_valid (sq_vld),
        .root      (sq_root)
    );

    ofr_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_vld_reg),
        .num       (s2_num_reg),
        .den       (den_reg),
        .out_valid (dv_vld),
        .quot      (dv_quot)
    );

    // ------------------------------------------------------------------
    // stages 3..8: area and area * coefficient
    // ------------------------------------------------------------------
    logic [ofr_pkg::SEAT_W-1:0]     seat_sum;
    side_t                          s2_side;
    side_t                          s3_side_reg;
    logic [ofr_pkg::PA_W+7:0]       s3_basep_reg;
    logic [ofr_pkg::G_W-1:0]        s3_g_reg;
    logic [ofr_pkg::X_W-1:0]        s3_x_reg;
    side_t                          s4_side_reg;
    logic [ofr_pkg::BASE_W-1:0]     s4_base_reg;
    side_t                          s5_side_reg;
    logic [ofr_pkg::BPI_W-1:0]      s5_pl_reg;
    logic [ofr_pkg::BPI_W-1:0]      s5_ph_reg;
    logic [ofr_pkg::BPI_FULL_W-1:0] bpi_sum;
    side_t                          s6_side_reg;
    logic [ofr_pkg::AREA_W-1:0]     s6_area_reg;
    side_t                          s7_side_reg;
    logic [ofr_pkg::AFC_W-1:0]      s7_p0_reg;
    logic [ofr_pkg::AFC_W-1:0]      s7_p1_reg;
    area_out_t                      s8_reg;

    assign s2_side  = '{vld: s2_vld_reg, neg: s2_neg_reg, sel: s2_sel_reg, zero: s2_zero_reg};
    // seat area: (d*2^24 + x*sqrt2) / 2^16
    assign seat_sum = {1'b0, bore_diameter_um_reg, 24'd0} + {1'b0, s2_xs_reg};
    assign bpi_sum  = {s5_ph_reg, {ofr_pkg::BASE_LO_W{1'b0}}} + ofr_pkg::BPI_FULL_W'(s5_pl_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_side_reg <= '0;
            s4_side_reg <= '0;
            s5_side_reg <= '0;
            s6_side_reg <= '0;
            s7_side_reg <= '0;
            s8_reg      <= '0;
        end
        else
        begin
            s3_side_reg <= s2_side;
            s4_side_reg <= s3_side_reg;
            s5_side_reg <= s4_side_reg;
            s6_side_reg <= s5_side_reg;
            s7_side_reg <= s6_side_reg;
            s8_reg.side <= s7_side_reg;
            s8_reg.p    <= ofr_pkg::AP_W'(s7_p0_reg)
                           + {s7_p1_reg, {ofr_pkg::AREA_LO_W{1'b0}}};
        end
    end

    always_ff @(posedge clk)
    begin
        s3_basep_reg <= {s2_pa_reg, 8'd0};
        s3_g_reg     <= seat_sum[ofr_pkg::SEAT_W-1:16];
        s3_x_reg     <= s2_x_reg;
        s4_base_reg  <= (area_mode_reg == ofr_pkg::AREA_PISTON)
                        ? ofr_pkg::BASE_W'(s3_basep_reg)
                        : s3_x_reg * s3_g_reg;
        // base * pi split in halves to keep each multiplier small
        s5_pl_reg    <= s4_base_reg[ofr_pkg::BASE_LO_W-1:0] * ofr_pkg::PI_Q16;
        s5_ph_reg    <= s4_base_reg[ofr_pkg::BASE_W-1:ofr_pkg::BASE_LO_W] * ofr_pkg::PI_Q16;
        s6_area_reg  <= bpi_sum[ofr_pkg::BPI_FULL_W-1:24];
        s7_p0_reg    <= s6_area_reg[ofr_pkg::AREA_LO_W-1:0] * flow_coeff_reg;
        s7_p1_reg    <= s6_area_reg[ofr_pkg::AREA_W-1:ofr_pkg::AREA_LO_W] * flow_coeff_reg;
    end

    // ------------------------------------------------------------------
    // alignment of the three paths
    // ------------------------------------------------------------------
    area_out_t         al_area;
    logic              al_sq_vld;
    ofr_pkg::sq_root_t al_root;
    logic              al_dv_vld;
    ofr_pkg::quot_t    al_quot;

    if (ofr_pkg::AREA_DLY == 0) begin : g_area_nodly
        assign al_area = s8_reg;
    end
    else begin : g_area_dly
        area_out_t dly_reg [ofr_pkg::AREA_DLY];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                for (int k = 0; k < ofr_pkg::AREA_DLY; k++)
                begin
                    dly_reg[k] <= '0;
                end
            end
            else
            begin
                dly_reg[0] <= s8_reg;
                for (int k = 1; k < ofr_pkg::AREA_DLY; k++)
                begin
                    dly_reg[k] <= dly_reg[k-1];
                end
            end
        end

        assign al_area = dly_reg[ofr_pkg::AREA_DLY-1];
    end

    if (ofr_pkg::SQ_DLY == 0) begin : g_sq_nodly
        assign al_sq_vld = sq_vld;
        assign al_root   = sq_root;
    end
    else begin : g_sq_dly
        logic              vld_reg  [ofr_pkg::SQ_DLY];
        ofr_pkg::sq_root_t root_reg [ofr_pkg::SQ_DLY];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                for (int k = 0; k < ofr_pkg::SQ_DLY; k++)
                begin
                    vld_reg[k] <= 1'b0;
                end
            end
            else
            begin
                vld_reg[0] <= sq_vld;
                for (int k = 1; k < ofr_pkg::SQ_DLY; k++)
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            root_reg[0] <= sq_root;
            for (int k = 1; k < ofr_pkg::SQ_DLY; k++)
            begin
                root_reg[k] <= root_reg[k-1];
            end
        end

        assign al_sq_vld = vld_reg[ofr_pkg::SQ_DLY-1];
        assign al_root   = root_reg[ofr_pkg::SQ_DLY-1];
    end

    if (ofr_pkg::DIV_DLY == 0) begin : g_dv_nodly
        assign al_dv_vld = dv_vld;
        assign al_quot   = dv_quot;
    end
    else begin : g_dv_dly
        logic           vld_reg  [ofr_pkg::DIV_DLY];
        ofr_pkg::quot_t quot_reg [ofr_pkg::DIV_DLY];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                for (int k = 0; k < ofr_pkg::DIV_DLY; k++)
                begin
                    vld_reg[k] <= 1'b0;
                end
            end
            else
            begin
                vld_reg[0] <= dv_vld;
                for (int k = 1; k < ofr_pkg::DIV_DLY; k++)
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            quot_reg[0] <= dv_quot;
            for (int k = 1; k < ofr_pkg::DIV_DLY; k++)
            begin
                quot_reg[k] <= quot_reg[k-1];
            end
        end

        assign al_dv_vld = vld_reg[ofr_pkg::DIV_DLY-1];
        assign al_quot   = quot_reg[ofr_pkg::DIV_DLY-1];
    end

    // ------------------------------------------------------------------
    // root select, final product, saturation
    // ------------------------------------------------------------------
    side_t                      m_side_reg;
    logic [ofr_pkg::SR_W-1:0]   m_sr_reg;
    ofr_pkg::sq_root_t          m_root_reg;
    logic [ofr_pkg::AP_W-1:0]   m_p_reg;
    side_t                      r_side_reg;
    ofr_pkg::rt_t               r_rt_reg;
    logic [ofr_pkg::AP_W-1:0]   r_p_reg;
    side_t                      f1_side_reg;
    logic [ofr_pkg::PP_W-1:0]   f1_lo_reg;
    logic [ofr_pkg::PP_W-1:0]   f1_hi_reg;
    side_t                      f2_side_reg;
    ofr_pkg::prod_t             f2_prod_reg;
    ofr_pkg::mag_t              mag_full;
    logic                       mag_over;
    ofr_pkg::flow_t             mag_clip;
    logic                       done_reg;
    ofr_pkg::flow_t             flow_reg;
    logic                       sat_reg;

    assign mag_full = f2_prod_reg[ofr_pkg::PROD_W-1:ofr_pkg::MAG_SH];
    assign mag_over = (mag_full > ofr_pkg::mag_t'(ofr_pkg::FLOW_LIMIT));
    assign mag_clip = mag_over ? ofr_pkg::FLOW_LIMIT : mag_full[ofr_pkg::FLOW_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_side_reg  <= '0;
            r_side_reg  <= '0;
            f1_side_reg <= '0;
            f2_side_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            m_side_reg  <= '{vld: al_sq_vld, neg: al_area.side.neg,
                             sel: al_area.side.sel, zero: al_area.side.zero};
            r_side_reg  <= m_side_reg;
            f1_side_reg <= r_side_reg;
            f2_side_reg <= f1_side_reg;
            done_reg    <= f2_side_reg.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        // sqrt(T) times the quadratic factor, scaled by 2^20
        m_sr_reg    <= al_root * al_quot;
        m_root_reg  <= al_root;
        m_p_reg     <= al_area.p;
        r_rt_reg    <= m_side_reg.zero ? '0
                       : m_side_reg.sel ? m_root_reg
                       : m_sr_reg[ofr_pkg::RT_W+ofr_pkg::DIV_FRAC-1:ofr_pkg::DIV_FRAC];
        r_p_reg     <= m_p_reg;
        f1_lo_reg   <= r_p_reg[ofr_pkg::AP_LO_W-1:0] * r_rt_reg;
        f1_hi_reg   <= r_p_reg[ofr_pkg::AP_W-1:ofr_pkg::AP_LO_W] * r_rt_reg;
        f2_prod_reg <= ofr_pkg::PROD_W'(f1_lo_reg) + {f1_hi_reg, {ofr_pkg::AP_LO_W{1'b0}}};
        flow_reg    <= f2_side_reg.neg ? (ofr_pkg::flow_t'(0) - mag_clip) : mag_clip;
        sat_reg     <= mag_over;
    end

    assign done       = done_reg;
    assign flow_mm3_s = flow_reg;
    assign saturated  = sat_reg;

`ifndef SYNTHESIS
    // area path sideband must line up with the root pipeline
    a_area_align: assert property (@(posedge clk) disable iff (!rst_n)
        al_area.side.vld == al_sq_vld)
        else $error("area path out of step with root pipeline");

    // coefficient divider must line up with the root pipeline
    a_div_align: assert property (@(posedge clk) disable iff (!rst_n)
        al_dv_vld == al_sq_vld)
        else $error("divider out of step with root pipeline");

    // a clipped word carries exactly the limit magnitude
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && sat_reg) |->
        ((flow_reg == ofr_pkg::FLOW_LIMIT)
         || (flow_reg == (ofr_pkg::flow_t'(0) - ofr_pkg::FLOW_LIMIT))))
        else $error("saturated word without limit value");
`endif

endmodule

FILE: verif/tb.sv
// self-checking testbench for the orifice flow rate pipeline
`timescale 1ns / 1ps

module tb;

    // no word accepted in either direction for this many cycles ends the run
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES = 8;
    localparam int WORDS_PER_PHASE = 50;

    typedef struct packed {
        logic [ofr_pkg::FLOW_W-1:0] flow;
        logic                       sat;
    } flow_word_t;

    // predicts the flow of each accepted word and checks the results in order
    class flow_scoreboard;
        bit [63:0]  mode;
        bit [63:0]  bore;
        bit [63:0]  coeff;
        bit [63:0]  thresh;
        flow_word_t pending[$];
        int         errors;

        function new();
            mode = 1;
            bore = 10000;
            coeff = 570;
            thresh = 10000;
            errors = 0;
        endfunction

        function void set_reg(ofr_pkg::cfg_index_t idx, logic [ofr_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                ofr_pkg::CFG_AREA_MODE:     mode = 64'(data[0]);
                ofr_pkg::CFG_BORE_DIAMETER: bore = 64'(data[ofr_pkg::D_W-1:0]);
                ofr_pkg::CFG_FLOW_COEFF:    coeff = 64'(data[ofr_pkg::FC_W-1:0]);
                ofr_pkg::CFG_REG_THRESHOLD: thresh = 64'(data[ofr_pkg::T_W-1:0]);
                default: ;
            endcase
        endfunction

        function bit [63:0] int_sqrt(bit [63:0] v);
            bit [63:0] r;
            bit [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        // sqrt above the threshold, matched quadratic at or below it
        function bit [63:0] soft_root(bit [63:0] dp);
            bit [63:0] num;
            bit [63:0] den;
            bit [63:0] quot;
            bit [63:0] s;
            if (dp > thresh)
                return int_sqrt(dp << (2 * ofr_pkg::ROOT_FRAC_BITS));
            if (dp == 0)
                return 0;
            num = dp * (3 * thresh - dp);
            den = 2 * thresh * thresh;
            quot = (num << 20) / den;
            s = int_sqrt(thresh << (2 * ofr_pkg::ROOT_FRAC_BITS));
            return (s * quot) >> 20;
        endfunction

        function void note_word(logic signed [ofr_pkg::PRES_W-1:0] pin,
                                logic signed [ofr_pkg::PRES_W-1:0] pout,
                                logic signed [ofr_pkg::OPEN_W-1:0] xo);
            longint     diff;
            bit         neg;
            bit [63:0]  dp;
            bit [63:0]  x;
            bit [63:0]  g;
            bit [63:0]  b;
            bit [63:0]  ar;
            bit [63:0]  rt;
            bit [63:0]  af;
            bit [127:0] prod;
            bit [63:0]  mag;
            flow_word_t w;
            diff = longint'(pin) - longint'(pout);
            neg = diff < 0;
            dp = neg ? 64'(-diff) : 64'(diff);
            x = (xo < 0) ? 64'd0 : 64'(xo);
            if (mode[0] == ofr_pkg::AREA_SEAT)
            begin
                g = ((bore << 24) + x * 64'(ofr_pkg::SQRT2_Q24)) >> 16;
                b = x * g;
            end
            else
                b = (bore * x) << 8;
            ar = (b * 64'(ofr_pkg::PI_Q16)) >> 24;
            rt = soft_root(dp);
            af = ar * coeff;
            prod = {64'd0, af} * {64'd0, rt};
            w.sat = 1'b0;
            if (prod[127:96] != 0)
            begin
                w.sat = 1'b1;
                mag = 64'(ofr_pkg::FLOW_LIMIT);
            end
            else
            begin
                mag = prod[95:32];
                if (mag > 64'(ofr_pkg::FLOW_LIMIT))
                begin
                    w.sat = 1'b1;
                    mag = 64'(ofr_pkg::FLOW_LIMIT);
                end
            end
            w.flow = neg ? ofr_pkg::FLOW_W'(-mag) : ofr_pkg::FLOW_W'(mag);
            pending = {pending, w};
        endfunction

        function void check_word(logic [ofr_pkg::FLOW_W-1:0] flow, logic sat);
            flow_word_t w;
            if (pending.size() == 0)
            begin
                $error("result with no word in flight: flow %0d", $signed(flow));
                errors++;
                return;
            end
            w = pending.pop_front();
            if (flow !== w.flow)
            begin
                $error("flow_mm3_s expected %0d actual %0d", $signed(w.flow), $signed(flow));
                errors++;
            end
            if (sat !== w.sat)
            begin
                $error("saturated expected %0d actual %0d", w.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic signed [ofr_pkg::PRES_W-1:0] pressure_in_pa;
    logic signed [ofr_pkg::PRES_W-1:0] pressure_out_pa;
    logic signed [ofr_pkg::OPEN_W-1:0] opening_um;
    logic                              done;
    logic signed [ofr_pkg::FLOW_W-1:0] flow_mm3_s;
    logic                              saturated;
    logic                              cfg_wr_en;
    logic [ofr_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [ofr_pkg::CFG_DATA_W-1:0]    cfg_data;

    flow_scoreboard sb;
    int             quiet_cycles = 0;

    orifice_flow_rate dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .pressure_in_pa  (pressure_in_pa),
        .pressure_out_pa (pressure_out_pa),
        .opening_um      (opening_um),
        .done            (done),
        .flow_mm3_s      (flow_mm3_s),
        .saturated       (saturated),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // monitor: values seen here are the ones before this edge's updates
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_word(pressure_in_pa, pressure_out_pa, opening_um);
            if (done)
                sb.check_word(flow_mm3_s, saturated);
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL orifice_flow_rate");
            $finish;
        end
    end

    // offer one word and hold it until it is taken; start stays high for the next word
    task automatic send_word(logic signed [ofr_pkg::PRES_W-1:0] pin,
                             logic signed [ofr_pkg::PRES_W-1:0] pout,
                             logic signed [ofr_pkg::OPEN_W-1:0] xo);
        start <= 1'b1;
        pressure_in_pa <= pin;
        pressure_out_pa <= pout;
        opening_um <= xo;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // a zero-length pause keeps start high so the next burst follows at once
    task automatic pause_sender(int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // registers are read live, so let every word in flight come out first
    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // back to back writes keep the enable high; cfg_done lowers it
    task automatic write_reg(ofr_pkg::cfg_index_t idx, logic [ofr_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        sb.set_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic cfg_done();
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // random word: mostly small pressure differences around the threshold
    task automatic random_word();
        logic signed [ofr_pkg::PRES_W-1:0] pin;
        logic signed [ofr_pkg::PRES_W-1:0] pout;
        logic signed [ofr_pkg::OPEN_W-1:0] xo;
        int                                span;
        pin = ofr_pkg::PRES_W'($urandom());
        span = (sb.thresh == 0) ? 4 : int'(sb.thresh) * 2 + 2;
        case ($urandom_range(0, 9))
            0, 1:    pout = ofr_pkg::PRES_W'($urandom());
            2:       pout = pin;
            3:       pout = pin + ofr_pkg::PRES_W'(sb.thresh);
            default: pout = pin + ofr_pkg::PRES_W'($urandom_range(0, span))
                            - ofr_pkg::PRES_W'(span / 2);
        endcase
        case ($urandom_range(0, 5))
            0:       xo = ofr_pkg::OPEN_W'($urandom());
            1:       xo = -ofr_pkg::OPEN_W'($urandom_range(1, 100000));
            2:       xo = ofr_pkg::OPEN_W'($urandom_range(0, 100));
            default: xo = ofr_pkg::OPEN_W'($urandom_range(0, 100000));
        endcase
        send_word(pin, pout, xo);
    endtask

    initial
    begin
        logic [ofr_pkg::CFG_DATA_W-1:0] mode_set[PHASES];
        logic [ofr_pkg::CFG_DATA_W-1:0] bore_set[PHASES];
        logic [ofr_pkg::CFG_DATA_W-1:0] coeff_set[PHASES];
        logic [ofr_pkg::CFG_DATA_W-1:0] thresh_set[PHASES];
        int                             left;
        int                             burst;

        sb = new();
        start = 1'b0;
        pressure_in_pa = '0;
        pressure_out_pa = '0;
        opening_um = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words under the reset settings
        send_word(28'sd100000, 28'sd0, 18'sd1000);
        send_word(28'sd0, 28'sd100000, 18'sd1000);
        send_word(28'sd5000, 28'sd5000, 18'sd1000);          // equal pressures
        send_word(28'sd10000, 28'sd0, 18'sd1000);            // exactly at the threshold
        send_word(28'sd9999, 28'sd0, 18'sd1000);
        send_word(28'sd10001, 28'sd0, 18'sd1000);
        send_word(28'sd1, 28'sd0, 18'sd131071);
        send_word(28'sd0, 28'sd1, 18'sd500);
        send_word(28'sd100000, 28'sd0, -18'sd1);             // negative opening
        send_word(28'sd100000, 28'sd0, -18'sd131072);
        send_word(28'sd100000, 28'sd0, 18'sd0);
        send_word(28'sd134217727, -28'sd134217728, 18'sd131071);  // widest difference
        send_word(-28'sd134217728, 28'sd134217727, 18'sd131071);
        send_word(-28'sd100000000, 28'sd100000000, 18'sd100000);
        drain();

        // directed words under extreme registers, seat mode and a zero threshold
        write_reg(ofr_pkg::CFG_AREA_MODE, 24'd0);
        write_reg(ofr_pkg::CFG_BORE_DIAMETER, 24'hFFFFFF);
        write_reg(ofr_pkg::CFG_FLOW_COEFF, 24'hFFFFFF);
        write_reg(ofr_pkg::CFG_REG_THRESHOLD, 24'd0);
        cfg_done();
        send_word(28'sd134217727, -28'sd134217728, 18'sd131071);  // overflow
        send_word(-28'sd134217728, 28'sd134217727, 18'sd131071);
        send_word(28'sd1, 28'sd0, 18'sd1);
        send_word(28'sd0, 28'sd0, 18'sd131071);              // zero threshold, no difference
        send_word(28'sd0, 28'sd2, 18'sd7);
        drain();

        // register sets per phase: extremes first, then random
        mode_set[0] = 24'd1; bore_set[0] = 24'd0;      coeff_set[0] = 24'd0;
        thresh_set[0] = 24'd1;
        mode_set[1] = 24'd0; bore_set[1] = 24'd100000; coeff_set[1] = 24'd16777215;
        thresh_set[1] = 24'd1000000;
        mode_set[2] = 24'd1; bore_set[2] = 24'd131071; coeff_set[2] = 24'd570;
        thresh_set[2] = 24'd1048575;
        mode_set[3] = 24'd0; bore_set[3] = 24'd10000;  coeff_set[3] = 24'd570;
        thresh_set[3] = 24'd10000;
        for (int p = 4; p < PHASES; p++)
        begin
            mode_set[p] = ofr_pkg::CFG_DATA_W'($urandom());
            bore_set[p] = ($urandom_range(0, 3) == 0)
                          ? ofr_pkg::CFG_DATA_W'($urandom())
                          : ofr_pkg::CFG_DATA_W'($urandom_range(0, 100000));
            coeff_set[p] = ($urandom_range(0, 1) == 0)
                           ? ofr_pkg::CFG_DATA_W'($urandom())
                           : ofr_pkg::CFG_DATA_W'($urandom_range(1, 5000));
            thresh_set[p] = ($urandom_range(0, 3) == 0)
                            ? ofr_pkg::CFG_DATA_W'($urandom())
                            : ofr_pkg::CFG_DATA_W'($urandom_range(0, 100000));
        end

        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(ofr_pkg::CFG_AREA_MODE, mode_set[p]);
            write_reg(ofr_pkg::CFG_BORE_DIAMETER, bore_set[p]);
            write_reg(ofr_pkg::CFG_FLOW_COEFF, coeff_set[p]);
            write_reg(ofr_pkg::CFG_REG_THRESHOLD, thresh_set[p]);
            cfg_done();
            left = WORDS_PER_PHASE;
            while (left > 0)
            begin
                // bursts of random length, some of them long with no gaps at all
                burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 8);
                if (burst > left)
                    burst = left;
                repeat (burst) random_word();
                left -= burst;
                pause_sender($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20));
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS orifice_flow_rate");
        else
            $display("FAIL orifice_flow_rate");
        $finish;
    end

endmodule

FILE: orifice_flow_rate.f
rtl/core/ofr_pkg.sv
rtl/core/ofr_isqrt.sv
rtl/core/ofr_div.sv
rtl/core/orifice_flow_rate.sv
verif/tb.sv
